// ----- hdl/mbps_pkg.sv -----
// Shared types and constants for the masked byte pattern search block.
// Depends on nothing; every other file refers to it by scoped names.
package mbps_pkg;

   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 6;
   localparam int OFFSET_W = 24;
   localparam int LENGTH_W = 7;
   localparam int OPCODE_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [OFFSET_W-1:0] OFFSET_FULL = 24'hFFFFFF;

   localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_DATA    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEARCH_RANGE   = 2'd1;

   // controls broadcast to every cell of the chain
   typedef struct packed {
      logic              shift;      // data item: window moves one cell
      logic              rotate;     // pattern ring moves one cell
      logic [BYTE_W-1:0] load_byte;
      logic              load_mark;
   } cell_ctrl_type;

   typedef struct packed {
      logic                match_found;
      logic [OFFSET_W-1:0] match_offset;
   } result_type;

endpackage

// ----- hdl/masked_byte_pattern_search.sv -----
// Masked byte pattern search, top level: chain of compare cells plus result buffer.
// A data item's result goes into the result buffer's output register, or into its skid register while that is held.
// Throughput: one item per cycle unless the result buffer is full; a pattern_length write
//   starts a realignment of the pattern ring, one cell per cycle, with no item taken.
// Reset (synchronous, active high): length 1, full search range, offset and found
//   flag cleared, result buffer empty. Pattern bytes stay undefined until loaded.
module masked_byte_pattern_search #(
   parameter int PATTERN_MAX = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // entry_index[5:0], byte_value[13:6],
                                                           // ignore_mark[14], zero[15]
   input  logic [mbps_pkg::OPCODE_W-1:0]       req_tuser,  // opcode[1:0]
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mbps_pkg::OFFSET_W-1:0]       rsp_tdata,  // match_offset[23:0]
   output logic                                rsp_tuser,  // match_found[0]
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mbps_pkg::OFFSET_W-1:0]       csr_data
);

   // Pattern entry idx sits in ring cell (align - idx) mod PATTERN_MAX, where
   // align = used length - 1, so cell j always compares against window byte j.
   localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int TW = AW + 2;
   localparam logic [mbps_pkg::OFFSET_W-1:0] PMAX = mbps_pkg::OFFSET_W'(PATTERN_MAX);

   // configuration
   logic [mbps_pkg::LENGTH_W-1:0] length_ff, length_in;
   logic [mbps_pkg::OFFSET_W-1:0] range_ff, range_in;

   // search state
   logic [mbps_pkg::OFFSET_W-1:0] seen_ff, seen_in;
   logic                          found_ff, found_in;
   logic [AW-1:0]                 align_ff, align_in;

   // request fields
   logic [mbps_pkg::INDEX_W-1:0]  ld_idx;
   logic [mbps_pkg::BYTE_W-1:0]   ld_byte;
   logic                          ld_mark;
   logic                          accept;
   logic                          is_load, is_restart, is_data;

   logic [mbps_pkg::OFFSET_W-1:0] used_len;
   logic [AW-1:0]                 align_goal;
   logic                          busy;
   logic [TW-1:0]                 load_cell;
   logic                          load_ok;

   mbps_pkg::cell_ctrl_type       ctrl;
   mbps_pkg::result_type          result;
   logic                          q_full;

   logic [mbps_pkg::BYTE_W-1:0]   win_q [PATTERN_MAX];
   logic [mbps_pkg::BYTE_W-1:0]   pat_q [PATTERN_MAX];
   logic                          ign_q [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]        cell_match;
   logic                          all_match;

   assign ld_idx  = req_tdata[5:0];
   assign ld_byte = req_tdata[13:6];
   assign ld_mark = req_tdata[14];

   // length 0 counts as 1, anything above the ring size as the ring size
   always_comb begin
      used_len = mbps_pkg::OFFSET_W'(length_ff);
      if (length_ff == '0) begin
         used_len = mbps_pkg::OFFSET_W'(1);
      end else if (used_len > PMAX) begin
         used_len = PMAX;
      end
   end

   assign align_goal = AW'(used_len - mbps_pkg::OFFSET_W'(1));
   assign busy       = (align_ff != align_goal);

   assign req_tready = !busy && !q_full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign is_load    = accept && (req_tuser == mbps_pkg::OP_LOAD);
   assign is_restart = accept && (req_tuser == mbps_pkg::OP_RESTART);
   assign is_data    = accept && (req_tuser == mbps_pkg::OP_DATA);

   // ring cell for a load: (align - idx) mod PATTERN_MAX
   always_comb begin
      load_cell = TW'(align_ff) + TW'(PATTERN_MAX) - TW'(ld_idx);
      if (load_cell >= TW'(PATTERN_MAX)) begin
         load_cell = load_cell - TW'(PATTERN_MAX);
      end
   end
   assign load_ok = is_load && (32'(ld_idx) < PATTERN_MAX);

   assign ctrl.shift     = is_data;
   assign ctrl.rotate    = busy;
   assign ctrl.load_byte = ld_byte;
   assign ctrl.load_mark = ld_mark;

   // the chain: window shifts toward higher cells, pattern ring rotates likewise
   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      localparam int PREV = (j == 0) ? PATTERN_MAX - 1 : j - 1;
      logic [mbps_pkg::BYTE_W-1:0] win_feed;
      logic                        we;
      logic                        act;

      if (j == 0) begin : g_head
         assign win_feed = ld_byte;
      end else begin : g_body
         assign win_feed = win_q[j-1];
      end
      assign we  = load_ok && (load_cell == TW'(j));
      assign act = (mbps_pkg::OFFSET_W'(j) < used_len);

      mbps_cell u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .load_we (we),
         .active  (act),
         .win_in  (win_feed),
         .win_out (win_q[j]),
         .pat_in  (pat_q[PREV]),
         .ign_in  (ign_q[PREV]),
         .pat_out (pat_q[j]),
         .ign_out (ign_q[j]),
         .match   (cell_match[j])
      );
   end

   assign all_match = &cell_match;

   // offset, found flag and the result of a data item
   always_comb begin
      logic [mbps_pkg::OFFSET_W-1:0] pos_next;
      logic [mbps_pkg::OFFSET_W-1:0] start;
      pos_next = seen_ff + mbps_pkg::OFFSET_W'(1);
      start    = pos_next - used_len;
      seen_in  = seen_ff;
      found_in = found_ff;
      result.match_found  = 1'b0;
      result.match_offset = '0;
      if (is_restart) begin
         seen_in  = '0;
         found_in = 1'b0;
      end else if (is_data && (seen_ff != mbps_pkg::OFFSET_FULL)) begin
         seen_in = pos_next;
         // need a full window since restart, start inside the range, first hit only
         if (!found_ff && (pos_next >= used_len) && (start < range_ff) && all_match) begin
            found_in            = 1'b1;
            result.match_found  = 1'b1;
            result.match_offset = start;
         end
      end
   end

   // register writes; other indexes are dropped
   always_comb begin
      length_in = length_ff;
      range_in  = range_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mbps_pkg::REG_PATTERN_LENGTH: length_in = csr_data[mbps_pkg::LENGTH_W-1:0];
            mbps_pkg::REG_SEARCH_RANGE:   range_in  = csr_data;
            default: ;
         endcase
      end
   end

   // ring realignment steps one cell per cycle until it fits the used length
   always_comb begin
      align_in = align_ff;
      if (busy) begin
         if (align_ff == AW'(PATTERN_MAX - 1)) begin
            align_in = '0;
         end else begin
            align_in = align_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= mbps_pkg::LENGTH_W'(1);
         range_ff  <= mbps_pkg::OFFSET_FULL;
         seen_ff   <= '0;
         found_ff  <= 1'b0;
         align_ff  <= '0;
      end else begin
         length_ff <= length_in;
         range_ff  <= range_in;
         seen_ff   <= seen_in;
         found_ff  <= found_in;
         align_ff  <= align_in;
      end
   end

   mbps_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (is_data),
      .push_data  (result),
      .full       (q_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- hdl/mbps_cell.sv -----
// One cell of the search chain: a window byte, a pattern byte and its mark.
// Depends on mbps_pkg.
module mbps_cell (
   input  logic                       clock,
   input  mbps_pkg::cell_ctrl_type    ctrl,
   input  logic                       load_we,
   input  logic                       active,
   input  logic [mbps_pkg::BYTE_W-1:0] win_in,
   output logic [mbps_pkg::BYTE_W-1:0] win_out,
   input  logic [mbps_pkg::BYTE_W-1:0] pat_in,
   input  logic                       ign_in,
   output logic [mbps_pkg::BYTE_W-1:0] pat_out,
   output logic                       ign_out,
   output logic                       match
);

   logic [mbps_pkg::BYTE_W-1:0] win_ff;
   logic [mbps_pkg::BYTE_W-1:0] pat_ff;
   logic                        ign_ff;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         win_ff <= win_in;
      end
      if (load_we) begin
         pat_ff <= ctrl.load_byte;
         ign_ff <= ctrl.load_mark;
      end else if (ctrl.rotate) begin
         pat_ff <= pat_in;
         ign_ff <= ign_in;
      end
   end

   // compared against the byte that is about to enter this cell
   assign match   = !active || ign_ff || (pat_ff == win_in);
   assign win_out = win_ff;
   assign pat_out = pat_ff;
   assign ign_out = ign_ff;

endmodule

// ----- hdl/mbps_out_queue.sv -----
// Two-entry result buffer: output register plus skid register.
// Depends on mbps_pkg.
module mbps_out_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  mbps_pkg::result_type           push_data,
   output logic                           full,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mbps_pkg::OFFSET_W-1:0]  rsp_tdata,
   output logic                           rsp_tuser
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   mbps_pkg::result_type out_ff, out_in;
   mbps_pkg::result_type skid_ff, skid_in;
   logic                 pop;

   assign pop = out_valid_ff && rsp_tready;

   // push is never raised while the skid entry is held
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            out_valid_in = push;
            out_in       = push_data;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full       = skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.match_offset;
   assign rsp_tuser  = out_ff.match_found;

endmodule
